// ----- src/assert_macros.svh -----
// Assertion macros shared by the pid step core modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that antecedent implies consequent on the same edge
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// check that antecedent implies consequent on the next edge
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/pidc_pkg.sv -----
// Package for the pid step core: payload structs, register indexes, constants.
// Used by every module of the block; depends on nothing.
package pidc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 64;
    localparam logic [32:0] DZ_POS = 33'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [32:0] DZ_INC = 33'(((64'd5 << FRAC_BITS) + 64'd5000) / 64'd10000);

    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_DRV_MAX = 3'd3;
    localparam logic [2:0] REG_DRV_MIN = 3'd4;
    localparam logic [2:0] REG_INT_LIM = 3'd5;
    localparam logic [2:0] REG_SEP_THR = 3'd6;
    localparam logic [2:0] REG_MODE    = 3'd7;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] measured;
        logic signed [31:0] setpoint;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               limited;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [31:0] drive_max;
        logic signed [31:0] drive_min;
        logic [30:0]        integral_limit;
        logic [30:0]        separation_threshold;
        logic [2:0]         loop_mode;
    } cfg_t;

    // datapath commands, one per step of the sequence
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_MUL_P,
        CMD_MUL_D,
        CMD_MUL_I,
        CMD_WEIGHT,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_DONE,
        CMD_SUM,
        CMD_CLAMP,
        CMD_STORE
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } dp_ctl_t;

    typedef struct packed {
        logic div_needed;
        logic div_last;
    } dp_sts_t;

    // saturate a sign/magnitude value (65-bit magnitude) to 32 bits
    function automatic logic signed [31:0] signed_from(input logic [64:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (m > 65'h80000000)
                r = 32'sh80000000;
            else
                r = 32'(-$signed({1'b0, m[31:0]}));
        end
        else begin
            if (m > 65'h7FFFFFFF)
                r = 32'sh7FFFFFFF;
            else
                r = $signed(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -36'sh080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- src/pidc_regs.sv -----
// APB-style configuration register file of the pid step core.
// Depends on pidc_pkg.
module pidc_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output pidc_pkg::cfg_t       cfg
);

    pidc_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p               <= '0;
            cfg_reg.gain_i               <= '0;
            cfg_reg.gain_d               <= '0;
            cfg_reg.drive_max            <= 32'sh7FFFFFFF;
            cfg_reg.drive_min            <= 32'sh80000000;
            cfg_reg.integral_limit       <= 31'h7FFFFFFF;
            cfg_reg.separation_threshold <= '0;
            cfg_reg.loop_mode            <= '0;
        end
        else if (wr)
        begin
            case (idx)
                pidc_pkg::REG_GAIN_P:  cfg_reg.gain_p <= pwdata;
                pidc_pkg::REG_GAIN_I:  cfg_reg.gain_i <= pwdata;
                pidc_pkg::REG_GAIN_D:  cfg_reg.gain_d <= pwdata;
                pidc_pkg::REG_DRV_MAX: cfg_reg.drive_max <= pwdata;
                pidc_pkg::REG_DRV_MIN: cfg_reg.drive_min <= pwdata;
                pidc_pkg::REG_INT_LIM: cfg_reg.integral_limit <= pwdata[30:0];
                pidc_pkg::REG_SEP_THR: cfg_reg.separation_threshold <= pwdata[30:0];
                pidc_pkg::REG_MODE:    cfg_reg.loop_mode <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pidc_pkg::REG_GAIN_P:  prdata = cfg_reg.gain_p;
            pidc_pkg::REG_GAIN_I:  prdata = cfg_reg.gain_i;
            pidc_pkg::REG_GAIN_D:  prdata = cfg_reg.gain_d;
            pidc_pkg::REG_DRV_MAX: prdata = cfg_reg.drive_max;
            pidc_pkg::REG_DRV_MIN: prdata = cfg_reg.drive_min;
            pidc_pkg::REG_INT_LIM: prdata = {1'b0, cfg_reg.integral_limit};
            pidc_pkg::REG_SEP_THR: prdata = {1'b0, cfg_reg.separation_threshold};
            pidc_pkg::REG_MODE:    prdata = {29'd0, cfg_reg.loop_mode};
            default:               prdata = '0;
        endcase
    end

endmodule

// ----- src/pidc_datapath.sv -----
// Datapath of the pid step core: error history, shared multiplier, restoring
// divider for the variable integral weight, sum, clamp and integral store.
// Depends on pidc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pidc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidc_pkg::cfg_t       cfg,
    input  pidc_pkg::in_word_t   in_word,
    input  pidc_pkg::dp_ctl_t    ctl,
    output pidc_pkg::dp_sts_t    sts,
    output pidc_pkg::out_word_t  result
);

    logic signed [32:0] e_last_reg, e_last_next;
    logic signed [32:0] e_prev_reg, e_prev_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] held_reg, held_next;

    logic signed [32:0] e_reg;
    logic signed [32:0] e1_reg;
    logic signed [32:0] e2_reg;
    logic [32:0]        ae_reg;
    logic signed [31:0] p_reg, d_reg, base_reg, ip_reg;
    logic signed [35:0] drv_reg, i_reg;
    logic               lim_reg;
    logic [63:0]        wprod_reg;
    logic [63:0]        quo_reg;
    logic [31:0]        rem_reg;
    logic [5:0]         cnt_reg;
    pidc_pkg::out_word_t result_reg;

    // shared multiplier: 32-bit magnitude by up to 35-bit magnitude
    logic signed [31:0] mul_g;
    logic signed [34:0] mul_x;
    logic [31:0]        mg;
    logic [34:0]        mx;
    logic [66:0]        mprod;
    logic [64:0]        mshift;
    logic signed [31:0] mul_res;
    logic signed [34:0] dd_x;

    assign dd_x = 35'(e_reg) - 35'(e1_reg) - 35'(e1_reg) + 35'(e2_reg);

    always_comb
    begin
        mul_g = cfg.gain_p;
        mul_x = 35'(e_reg);
        case (ctl.cmd)
            pidc_pkg::CMD_MUL_P:
            begin
                mul_g = cfg.gain_p;
                mul_x = cfg.loop_mode[0] ? 35'(e_reg) - 35'(e1_reg) : 35'(e_reg);
            end
            pidc_pkg::CMD_MUL_D:
            begin
                mul_g = cfg.gain_d;
                mul_x = cfg.loop_mode[0] ? dd_x : 35'(e_reg) - 35'(e1_reg);
            end
            pidc_pkg::CMD_MUL_I:
            begin
                mul_g = cfg.gain_i;
                mul_x = 35'(e_reg);
            end
            default: ;
        endcase
        mg      = mul_g[31] ? 32'(-mul_g) : mul_g;
        mx      = mul_x[34] ? 35'(-mul_x) : mul_x;
        mprod   = 67'(mg) * 67'(mx);
        mshift  = 65'(mprod >> pidc_pkg::FRAC_BITS);
        mul_res = pidc_pkg::signed_from(mshift, (mul_g[31] != mul_x[34]) && mprod != '0);
    end

    logic [31:0] base_mag;
    logic [31:0] thr_minus;
    assign base_mag  = base_reg[31] ? 32'(-base_reg) : base_reg;
    assign thr_minus = 32'({1'b0, cfg.separation_threshold}) - 32'(ae_reg);

    // restoring division step: partial remainder below 2^31
    logic [32:0] trial;
    assign trial = {rem_reg, wprod_reg[63]} - 33'({2'b0, cfg.separation_threshold});

    logic signed [35:0] drv_sum;
    logic signed [35:0] i_sum;
    logic signed [35:0] dmax, dmin;
    logic signed [35:0] ilim;
    logic [32:0]        dz;
    assign dz   = cfg.loop_mode[0] ? pidc_pkg::DZ_INC : pidc_pkg::DZ_POS;
    assign dmax = 36'(cfg.drive_max);
    assign dmin = 36'(cfg.drive_min);
    assign ilim = 36'({1'b0, cfg.integral_limit});

    always_comb
    begin
        if (!cfg.loop_mode[0])
        begin
            i_sum   = (ae_reg < dz) ? '0 : 36'(integ_reg) + 36'(ip_reg);
            drv_sum = 36'(p_reg) + i_sum + 36'(d_reg);
        end
        else
        begin
            i_sum   = (ae_reg < dz) ? '0 : 36'(ip_reg);
            drv_sum = 36'(held_reg) + 36'(p_reg) + i_sum + 36'(d_reg);
        end
    end

    always_comb
    begin
        e_last_next = e_last_reg;
        e_prev_next = e_prev_reg;
        integ_next  = integ_reg;
        held_next   = held_reg;
        case (ctl.cmd)
            pidc_pkg::CMD_CLEAR:
            begin
                e_last_next = '0;
                e_prev_next = '0;
                integ_next  = '0;
                held_next   = '0;
            end
            pidc_pkg::CMD_LOAD:
            begin
                e_prev_next = e_last_reg;
                e_last_next = 33'(in_word.setpoint) - 33'(in_word.measured);
            end
            pidc_pkg::CMD_STORE:
            begin
                held_next = drv_reg[31:0];
                if (!cfg.loop_mode[0])
                begin
                    if (i_reg > ilim)
                        integ_next = ilim[31:0];
                    else if (i_reg < -ilim)
                        integ_next = 32'(-ilim);
                    else
                        integ_next = i_reg[31:0];
                end
                else
                    integ_next = pidc_pkg::sat32(i_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_last_reg <= '0;
            e_prev_reg <= '0;
            integ_reg  <= '0;
            held_reg   <= '0;
        end
        else
        begin
            e_last_reg <= e_last_next;
            e_prev_reg <= e_prev_next;
            integ_reg  <= integ_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            pidc_pkg::CMD_LOAD:
            begin
                e_reg  <= 33'(in_word.setpoint) - 33'(in_word.measured);
                e1_reg <= e_last_reg;
                e2_reg <= e_prev_reg;
                ae_reg <= in_word.setpoint >= in_word.measured
                        ? 33'(33'(in_word.setpoint) - 33'(in_word.measured))
                        : 33'(33'(in_word.measured) - 33'(in_word.setpoint));
            end
            pidc_pkg::CMD_CLEAR:
                result_reg <= '0;
            pidc_pkg::CMD_MUL_P:
                p_reg <= mul_res;
            pidc_pkg::CMD_MUL_D:
                d_reg <= mul_res;
            pidc_pkg::CMD_MUL_I:
                base_reg <= mul_res;
            pidc_pkg::CMD_WEIGHT:
            begin
                if (cfg.loop_mode[2])
                    ip_reg <= '0;
                else if (cfg.loop_mode[1] && ae_reg > 33'(cfg.separation_threshold))
                    ip_reg <= '0;
                else
                    ip_reg <= base_reg;
                wprod_reg <= 64'(base_mag) * 64'(thr_minus);
            end
            pidc_pkg::CMD_DIV_INIT:
            begin
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            pidc_pkg::CMD_DIV_STEP:
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], wprod_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                wprod_reg <= {wprod_reg[62:0], 1'b0};
                cnt_reg   <= cnt_reg + 6'd1;
            end
            pidc_pkg::CMD_DIV_DONE:
                ip_reg <= pidc_pkg::signed_from({1'b0, quo_reg}, base_reg[31]);
            pidc_pkg::CMD_SUM:
            begin
                drv_reg <= drv_sum;
                i_reg   <= i_sum;
            end
            pidc_pkg::CMD_CLAMP:
            begin
                lim_reg <= 1'b0;
                if (drv_reg > dmax)
                begin
                    i_reg   <= i_reg - (drv_reg - dmax);
                    drv_reg <= dmax;
                    lim_reg <= 1'b1;
                end
                else if (drv_reg < dmin)
                begin
                    i_reg   <= i_reg - (drv_reg - dmin);
                    drv_reg <= dmin;
                    lim_reg <= 1'b1;
                end
            end
            pidc_pkg::CMD_STORE:
            begin
                result_reg.drive   <= drv_reg[31:0];
                result_reg.limited <= lim_reg;
            end
            default: ;
        endcase
    end

    assign sts.div_needed = cfg.loop_mode[2] && (ae_reg < 33'(cfg.separation_threshold));
    assign sts.div_last   = (cnt_reg == 6'(pidc_pkg::DIV_BITS - 1));
    assign result         = result_reg;

    `CHK_NEXT(a_clear_zero, clk, rst_n, ctl.cmd == pidc_pkg::CMD_CLEAR,
        integ_reg == '0 && held_reg == '0 && e_last_reg == '0)
    `CHK_NEXT(a_load_shift, clk, rst_n, ctl.cmd == pidc_pkg::CMD_LOAD,
        e_prev_reg == $past(e_last_reg))
    `CHK_NEXT(a_store_held, clk, rst_n, ctl.cmd == pidc_pkg::CMD_STORE,
        held_reg == result_reg.drive)

endmodule

// ----- src/pidc_ctrl.sv -----
// Sequencer of the pid step core: handshakes and issues datapath commands.
// Depends on pidc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pidc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pidc_pkg::dp_sts_t    sts,
    output pidc_pkg::dp_ctl_t    ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_D, S_MUL_I, S_WEIGHT, S_DIV_INIT, S_DIV,
        S_DIV_DONE, S_SUM, S_CLAMP, S_STORE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // a new word may enter once the previous result has left or leaves now
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl.cmd        = pidc_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (in_op == pidc_pkg::OP_CLEAR)
                    begin
                        ctl.cmd        = pidc_pkg::CMD_CLEAR;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        ctl.cmd    = pidc_pkg::CMD_LOAD;
                        state_next = S_MUL_P;
                    end
                end
            S_MUL_P:
            begin
                ctl.cmd    = pidc_pkg::CMD_MUL_P;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                ctl.cmd    = pidc_pkg::CMD_MUL_D;
                state_next = S_MUL_I;
            end
            S_MUL_I:
            begin
                ctl.cmd    = pidc_pkg::CMD_MUL_I;
                state_next = S_WEIGHT;
            end
            S_WEIGHT:
            begin
                ctl.cmd    = pidc_pkg::CMD_WEIGHT;
                state_next = sts.div_needed ? S_DIV_INIT : S_SUM;
            end
            S_DIV_INIT:
            begin
                ctl.cmd    = pidc_pkg::CMD_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctl.cmd = pidc_pkg::CMD_DIV_STEP;
                if (sts.div_last)
                    state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                ctl.cmd    = pidc_pkg::CMD_DIV_DONE;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                ctl.cmd    = pidc_pkg::CMD_SUM;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                ctl.cmd    = pidc_pkg::CMD_CLAMP;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                ctl.cmd        = pidc_pkg::CMD_STORE;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CHK_IMPL(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `CHK_NEXT(a_store_valid, clk, rst_n, state_reg == S_STORE, out_valid_reg)
    `CHK_IMPL(a_store_free, clk, rst_n, state_reg == S_STORE, !out_valid_reg)

endmodule

// ----- src/pid_controller_step_core.sv -----
// Fixed-point PID controller core, Q16.16 signed: one step or clear per input word.
// A step word is loaded on acceptance, then passes the multiply, weight, sum, clamp and
// store states; when the variable-integral weight is active, the 64-step restoring
// divider with its setup and finish states scales the integral contribution. A clear
// word is done on acceptance. One 32x35 multiplier is shared by the P, D and I products.
// The result word stays registered until taken; a new word is accepted in the cycle its
// predecessor's result leaves. Depends on pidc_pkg, pidc_regs, pidc_ctrl and pidc_datapath.
module pid_controller_step_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidc_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidc_pkg::out_word_t  out_data
);

    pidc_pkg::cfg_t    cfg;
    pidc_pkg::dp_ctl_t ctl;
    pidc_pkg::dp_sts_t sts;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    pidc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_word (in_data),
        .ctl     (ctl),
        .sts     (sts),
        .result  (out_data)
    );

endmodule
